// ===== rtl/led_matrix_frame_buffer_defines.svh =====
// assertion macros for the led matrix frame buffer
// used by the top level; expects clk and rst_n in scope
`ifndef LED_MATRIX_FRAME_BUFFER_DEFINES_SVH
`define LED_MATRIX_FRAME_BUFFER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LMFB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lmfb same-cycle check failed");

// next-cycle implication, disabled during reset
`define LMFB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lmfb next-cycle check failed");

`endif

// ===== rtl/lmfb_pkg.sv =====
// shared types, constants and font tables for the led matrix frame buffer
// no dependencies
package lmfb_pkg;

    localparam int PANEL_COUNT_DEF = 2;
    localparam int ROWS            = 8;
    localparam int ROW_W           = 3;
    localparam int OP_W            = 3;
    localparam int NUM_LIMIT       = 9999;
    localparam int NUM_W           = 14;
    localparam int DIG_W           = 4;
    localparam int RECIP           = 52429;
    localparam int RECIP_W         = 16;
    localparam int RECIP_SHIFT     = 19;
    localparam int Q_W             = 10;
    localparam int XPOS_W          = 4;
    localparam int DIGIT_COLS      = 3;
    localparam int GLYPH_COLS      = 4;
    localparam int GLYPH_X         = 6;
    localparam int FONT_H          = 5;
    localparam int GLYPH_H         = 6;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR,
        OP_SET,
        OP_GET,
        OP_SHL,
        OP_SHR,
        OP_COLUMN,
        OP_NUMBER,
        OP_COUNTDOWN
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_DIGIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic num_start;
        logic num_step;
        logic result_load;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic digit_last;
        logic out_free;
    } dp_status_t;

    typedef logic [DIGIT_COLS-1:0][FONT_H-1:0]  font_cols_t;
    typedef logic [GLYPH_COLS-1:0][GLYPH_H-1:0] glyph_cols_t;

    // 3x5 font, element 0 is the leftmost column
    function automatic font_cols_t font_cols(logic [DIG_W-1:0] d);
        font_cols_t f;
        case (d)
            4'd0:    f = {5'h1F, 5'h11, 5'h1F};
            4'd1:    f = {5'h00, 5'h1F, 5'h00};
            4'd2:    f = {5'h17, 5'h15, 5'h1D};
            4'd3:    f = {5'h1F, 5'h15, 5'h15};
            4'd4:    f = {5'h1F, 5'h04, 5'h07};
            4'd5:    f = {5'h1D, 5'h15, 5'h17};
            4'd6:    f = {5'h1D, 5'h15, 5'h1F};
            4'd7:    f = {5'h1F, 5'h01, 5'h01};
            4'd8:    f = {5'h1F, 5'h15, 5'h1F};
            4'd9:    f = {5'h1F, 5'h15, 5'h17};
            default: f = '0;
        endcase
        return f;
    endfunction

    // countdown glyphs; anything but 1 to 3 is blank
    function automatic glyph_cols_t glyph_cols(logic [7:0] d);
        glyph_cols_t g;
        case (d)
            8'd1:    g = {6'h20, 6'h3F, 6'h22, 6'h20};
            8'd2:    g = {6'h22, 6'h25, 6'h25, 6'h39};
            8'd3:    g = {6'h1A, 6'h25, 6'h25, 6'h21};
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

// ===== rtl/lmfb_ctrl.sv =====
// command sequencer for the led matrix frame buffer
// depends on lmfb_pkg
module lmfb_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  lmfb_pkg::dp_status_t   status,
    output lmfb_pkg::dp_cmd_t      cmd
);
    import lmfb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = (status.op == OP_NUMBER) ? ST_DIGIT : ST_DONE;
            end
            ST_DIGIT:
            begin
                if (status.digit_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_EXEC:
            begin
                cmd.num_start = (status.op == OP_NUMBER);
                cmd.exec      = (status.op != OP_NUMBER);
            end
            ST_DIGIT:
            begin
                cmd.num_step = 1'b1;
            end
            ST_DONE:
            begin
                cmd.result_load = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/lmfb_datapath.sv =====
// frame store, drawing logic, digit extraction and output register
// depends on lmfb_pkg
module lmfb_datapath #(
    parameter int PANEL_COUNT = lmfb_pkg::PANEL_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lmfb_pkg::dp_cmd_t           cmd,
    output lmfb_pkg::dp_status_t        status,
    input  logic [lmfb_pkg::OP_W-1:0]   operation,
    input  logic [7:0]                  pixel_x,
    input  logic [7:0]                  pixel_y,
    input  logic                        pixel_on,
    input  logic [7:0]                  column_bits,
    input  logic [15:0]                 number_value,
    input  logic [7:0]                  countdown_digit,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        pixel_value
);
    import lmfb_pkg::*;

    localparam int COLS  = PANEL_COUNT * 8;
    localparam int X_W   = $clog2(COLS);
    localparam int P_W   = (X_W > XPOS_W + 1) ? X_W : XPOS_W + 1;
    localparam int PRD_W = NUM_W + RECIP_W;

    op_t                 op_reg;
    logic [7:0]          x_reg;
    logic [7:0]          y_reg;
    logic                on_reg;
    logic [7:0]          colb_reg;
    logic [15:0]         num_reg;
    logic [7:0]          cd_reg;
    logic [COLS-1:0]     frame_reg  [ROWS];
    logic [COLS-1:0]     frame_next [ROWS];
    logic [NUM_W-1:0]    val_reg;
    logic [NUM_W-1:0]    val_next;
    logic [XPOS_W-1:0]   xpos_reg;
    logic [XPOS_W-1:0]   xpos_next;
    logic                out_valid_reg;
    logic                pixel_value_reg;

    logic                x_ok;
    logic                y_ok;
    logic [X_W-1:0]      xi;
    logic [ROW_W-1:0]    yi;
    logic                pixel_rd;
    logic [NUM_W-1:0]    num_sat;
    logic [PRD_W-1:0]    prod;
    logic [Q_W-1:0]      quot;
    logic [NUM_W-1:0]    quot_x10;
    logic [DIG_W-1:0]    digit;
    font_cols_t          font;
    glyph_cols_t         glyph;
    logic [COLS-1:0]     digit_rows [ROWS];
    logic [COLS-1:0]     cd_rows    [ROWS];

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg   <= op_t'(operation);
            x_reg    <= pixel_x;
            y_reg    <= pixel_y;
            on_reg   <= pixel_on;
            colb_reg <= column_bits;
            num_reg  <= number_value;
            cd_reg   <= countdown_digit;
        end
    end

    assign x_ok     = ({1'b0, x_reg} < 9'(COLS));
    assign y_ok     = (y_reg[7:ROW_W] == '0);
    assign xi       = x_reg[X_W-1:0];
    assign yi       = y_reg[ROW_W-1:0];
    assign pixel_rd = x_ok && y_ok && frame_reg[yi][xi];

    // saturated number and one decimal digit per step
    assign num_sat  = (num_reg > 16'(NUM_LIMIT)) ? NUM_W'(NUM_LIMIT) : num_reg[NUM_W-1:0];
    assign prod     = PRD_W'(val_reg) * PRD_W'(RECIP);
    assign quot     = prod[RECIP_SHIFT +: Q_W];
    assign quot_x10 = NUM_W'({quot, 3'b000}) + NUM_W'({quot, 1'b0});
    assign digit    = DIG_W'(val_reg - quot_x10);
    assign font     = font_cols(digit);
    assign glyph    = glyph_cols(cd_reg);

    always_comb
    begin
        logic [P_W-1:0] pos;
        for (int r = 0; r < ROWS; r++)
        begin
            digit_rows[r] = '0;
            cd_rows[r]    = '0;
        end
        // glyph columns sit one row down, row 0 stays dark
        for (int c = 0; c < DIGIT_COLS; c++)
        begin
            pos = P_W'(xpos_reg) + P_W'(c);
            if (int'(pos) < COLS)
            begin
                for (int r = 1; r <= FONT_H; r++)
                begin
                    digit_rows[r][pos[X_W-1:0]] = font[c][r-1];
                end
            end
        end
        for (int c = 0; c < GLYPH_COLS; c++)
        begin
            if (GLYPH_X + c < COLS)
            begin
                for (int r = 1; r <= GLYPH_H; r++)
                begin
                    cd_rows[r][GLYPH_X + c] = glyph[c][r-1];
                end
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < ROWS; r++)
        begin
            frame_next[r] = frame_reg[r];
        end
        val_next  = val_reg;
        xpos_next = xpos_reg;
        if (cmd.exec)
        begin
            case (op_reg)
                OP_CLEAR:
                begin
                    for (int r = 0; r < ROWS; r++)
                    begin
                        frame_next[r] = '0;
                    end
                end
                OP_SET:
                begin
                    if (x_ok && y_ok)
                    begin
                        frame_next[yi][xi] = on_reg;
                    end
                end
                OP_SHL:
                begin
                    for (int r = 0; r < ROWS; r++)
                    begin
                        frame_next[r] = frame_reg[r] >> 1;
                    end
                end
                OP_SHR:
                begin
                    for (int r = 0; r < ROWS; r++)
                    begin
                        frame_next[r] = frame_reg[r] << 1;
                    end
                end
                OP_COLUMN:
                begin
                    if (x_ok)
                    begin
                        for (int r = 0; r < ROWS; r++)
                        begin
                            frame_next[r][xi] = colb_reg[r];
                        end
                    end
                end
                OP_COUNTDOWN:
                begin
                    for (int r = 0; r < ROWS; r++)
                    begin
                        frame_next[r] = cd_rows[r];
                    end
                end
                default:
                begin
                    frame_next[0] = frame_reg[0];
                end
            endcase
        end
        if (cmd.num_start)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                frame_next[r] = '0;
            end
            val_next = num_sat;
            // centred start position by digit count
            if (num_sat < NUM_W'(10))
            begin
                xpos_next = XPOS_W'(6);
            end
            else if (num_sat < NUM_W'(100))
            begin
                xpos_next = XPOS_W'(8);
            end
            else if (num_sat < NUM_W'(1000))
            begin
                xpos_next = XPOS_W'(10);
            end
            else
            begin
                xpos_next = XPOS_W'(12);
            end
        end
        if (cmd.num_step)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                frame_next[r] = frame_reg[r] | digit_rows[r];
            end
            val_next  = NUM_W'(quot);
            xpos_next = xpos_reg - XPOS_W'(4);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                frame_reg[r] <= '0;
            end
        end
        else
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                frame_reg[r] <= frame_next[r];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        xpos_reg <= xpos_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            pixel_value_reg <= (op_reg == OP_GET) && pixel_rd;
        end
    end

    assign out_valid         = out_valid_reg;
    assign pixel_value       = pixel_value_reg;
    assign status.op         = op_reg;
    assign status.digit_last = (quot == '0);
    assign status.out_free   = !out_valid_reg || out_ready;

endmodule

// ===== rtl/led_matrix_frame_buffer.sv =====
// LED matrix frame buffer, 8 rows by PANEL_COUNT*8 columns, one drawing command
// per request and one pixel_value result per request. A request is taken only
// while no other is being worked on; a finished result waits in an output
// register, so the next request can be taken while it is still unclaimed. Clear,
// pixel, shift, column and countdown requests run a single execute step; a number
// clears the picture and runs a digit loop that extracts one digit per cycle with
// a reciprocal multiply until its last digit is drawn; each then waits for a free
// output register. The picture is cleared at reset with no clearing pass.
//
// top level; depends on lmfb_pkg, lmfb_ctrl, lmfb_datapath and the defines header
`include "led_matrix_frame_buffer_defines.svh"

module led_matrix_frame_buffer #(
    parameter int PANEL_COUNT = lmfb_pkg::PANEL_COUNT_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [lmfb_pkg::OP_W-1:0]   operation,
    input  logic [7:0]                  pixel_x,
    input  logic [7:0]                  pixel_y,
    input  logic                        pixel_on,
    input  logic [7:0]                  column_bits,
    input  logic [15:0]                 number_value,
    input  logic [7:0]                  countdown_digit,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        pixel_value
);
    import lmfb_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    lmfb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lmfb_datapath #(
        .PANEL_COUNT (PANEL_COUNT)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .operation       (operation),
        .pixel_x         (pixel_x),
        .pixel_y         (pixel_y),
        .pixel_on        (pixel_on),
        .column_bits     (column_bits),
        .number_value    (number_value),
        .countdown_digit (countdown_digit),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pixel_value     (pixel_value)
    );

    // one request in flight at a time
    `LMFB_ASSERT_NXT(a_busy_after_request, in_valid && in_ready, !in_ready)
    // a result only moves into a free output register
    `LMFB_ASSERT_IMP(a_result_room, cmd.result_load, !out_valid || out_ready)
    `LMFB_ASSERT_NXT(a_result_shown, cmd.result_load, out_valid)

endmodule
